@@ src/thermal_pwm_derating_top_assert.svh @@
// assertion macros for the thermal pwm derating block
`ifndef THERMAL_PWM_DERATING_TOP_ASSERT_SVH
`define THERMAL_PWM_DERATING_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define TPD_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TPD_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define TPD_ASSERT_NOW(label, cond, prop, msg)
`define TPD_ASSERT_NXT(label, cond, prop, msg)

`endif

`endif

@@ src/tpd_pkg.sv @@
// shared types, codes and constants for the thermal pwm derating block
package tpd_pkg;

	localparam int TEMP_W     = 16;
	localparam int DUTY_W     = 8;
	localparam int CLS_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// product of temperature distance and duty span
	localparam int PROD_W = TEMP_W + DUTY_W;
	// quotient never exceeds the duty span
	localparam int QUOT_W = DUTY_W;

	// divider split: quotient bits resolved per pipeline stage
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_MAX   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR   = 2'd3;

	// register reset values
	localparam logic signed [TEMP_W-1:0] RST_NORMAL_MAX   = 16'sd960;
	localparam logic signed [TEMP_W-1:0] RST_THROTTLE_MAX = 16'sd1200;
	localparam logic signed [TEMP_W-1:0] RST_CRITICAL     = 16'sd1360;
	localparam logic [DUTY_W-1:0]        RST_DUTY_FLOOR   = 8'd0;

	// thermal class codes
	localparam logic [CLS_W-1:0] CLS_NORMAL   = 2'd0;
	localparam logic [CLS_W-1:0] CLS_THROTTLE = 2'd1;
	localparam logic [CLS_W-1:0] CLS_CRITICAL = 2'd2;
	localparam logic [CLS_W-1:0] CLS_UNUSED   = 2'd3;

	// duty selection codes
	localparam logic [1:0] MODE_FLOOR = 2'd0;
	localparam logic [1:0] MODE_REQ   = 2'd1;
	localparam logic [1:0] MODE_RAMP  = 2'd2;

	typedef struct packed {
		logic signed [TEMP_W-1:0] normal_max_temp;
		logic signed [TEMP_W-1:0] throttle_max_temp;
		logic signed [TEMP_W-1:0] critical_temp;
		logic [DUTY_W-1:0]        duty_floor;
	} cfg_t;

	// word after the compare stage
	typedef struct packed {
		logic [1:0]        mode;
		logic [CLS_W-1:0]  cls;
		logic [DUTY_W-1:0] req;
		logic [DUTY_W-1:0] floor_duty;
		logic [TEMP_W-1:0] num;
		logic [TEMP_W-1:0] den;
		logic [DUTY_W-1:0] span;
	} prep_t;

	// word through the multiply and divide stages
	typedef struct packed {
		logic [1:0]        mode;
		logic [CLS_W-1:0]  cls;
		logic [DUTY_W-1:0] req;
		logic [DUTY_W-1:0] floor_duty;
		logic [TEMP_W-1:0] den;
		logic [PROD_W-1:0] rem;
		logic [QUOT_W-1:0] quot;
	} work_t;

endpackage

@@ src/tpd_regs.sv @@
// configuration register file for the derating thresholds and duty floor
module tpd_regs
	import tpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, unused indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_max_temp   <= RST_NORMAL_MAX;
			cfg_q.throttle_max_temp <= RST_THROTTLE_MAX;
			cfg_q.critical_temp     <= RST_CRITICAL;
			cfg_q.duty_floor        <= RST_DUTY_FLOOR;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NORMAL_MAX:   cfg_q.normal_max_temp   <= cfg_data[TEMP_W-1:0];
				REG_THROTTLE_MAX: cfg_q.throttle_max_temp <= cfg_data[TEMP_W-1:0];
				REG_CRITICAL:     cfg_q.critical_temp     <= cfg_data[TEMP_W-1:0];
				REG_DUTY_FLOOR:   cfg_q.duty_floor        <= cfg_data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/tpd_prep.sv @@
// first stage: threshold compares, class, ramp distance, divisor and span
module tpd_prep
	import tpd_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  cfg_t              cfg,
	input  logic [TEMP_W-1:0] temperature,
	input  logic [DUTY_W-1:0] requested_duty,
	output prep_t             q
);

	logic signed [TEMP_W-1:0] t;
	logic signed [TEMP_W-1:0] t_norm;
	logic signed [TEMP_W-1:0] t_thr;
	logic signed [TEMP_W-1:0] t_crit;
	logic signed [TEMP_W:0]   num_w;
	logic signed [TEMP_W:0]   den_w;
	prep_t                    d;
	prep_t                    prep_s1;

	assign t      = temperature;
	assign t_norm = cfg.normal_max_temp;
	assign t_thr  = cfg.throttle_max_temp;
	assign t_crit = cfg.critical_temp;

	// distances are positive whenever the ramp is taken
	assign num_w = {t_thr[TEMP_W-1], t_thr} - {t[TEMP_W-1], t};
	assign den_w = {t_thr[TEMP_W-1], t_thr} - {t_norm[TEMP_W-1], t_norm};

	// duty selection in fixed priority, class on its own
	always_comb begin
		d.req        = requested_duty;
		d.floor_duty = cfg.duty_floor;
		d.num        = num_w[TEMP_W-1:0];
		d.den        = den_w[TEMP_W-1:0];
		d.span       = requested_duty - cfg.duty_floor;
		if (t >= t_crit || t >= t_thr) begin
			d.mode = MODE_FLOOR;
		end else if (t <= t_norm) begin
			d.mode = MODE_REQ;
		end else if (requested_duty < cfg.duty_floor) begin
			d.mode = MODE_REQ;
		end else begin
			d.mode = MODE_RAMP;
		end
		if (t >= t_crit) begin
			d.cls = CLS_CRITICAL;
		end else if (t >= t_norm) begin
			d.cls = CLS_THROTTLE;
		end else begin
			d.cls = CLS_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prep_s1 <= d;
		end
	end

	assign q = prep_s1;

endmodule

@@ src/tpd_mul.sv @@
// second stage: distance times duty span, seeds the divider remainder
module tpd_mul
	import tpd_pkg::*;
(
	input  logic  clk,
	input  logic  load,
	input  prep_t d,
	output work_t q
);

	work_t w;
	work_t work_s2;

	always_comb begin
		w.mode       = d.mode;
		w.cls        = d.cls;
		w.req        = d.req;
		w.floor_duty = d.floor_duty;
		w.den        = d.den;
		w.rem        = PROD_W'(d.num) * PROD_W'(d.span);
		w.quot       = '0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			work_s2 <= w;
		end
	end

	assign q = work_s2;

endmodule

@@ src/tpd_div_stage.sv @@
// one restoring divider stage, resolves DIV_BITS_PER_STAGE quotient bits msb first
module tpd_div_stage
	import tpd_pkg::*;
#(
	parameter int QBIT_HI = QUOT_W - 1
) (
	input  logic  clk,
	input  logic  load,
	input  work_t d,
	output work_t q
);

	work_t             w;
	work_t             div_s;
	logic [PROD_W-1:0] dsh;
	logic              hit;

	// compare and subtract against the shifted divisor, shift in quotient bit
	always_comb begin
		w   = d;
		dsh = '0;
		hit = 1'b0;
		for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
			dsh    = PROD_W'(d.den) << (QBIT_HI - k);
			hit    = (w.rem >= dsh);
			w.rem  = hit ? (w.rem - dsh) : w.rem;
			w.quot = {w.quot[QUOT_W-2:0], hit};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			div_s <= w;
		end
	end

	assign q = div_s;

endmodule

@@ src/thermal_pwm_derating_top.sv @@
// top level of the thermal pwm derating pipeline
// Thermal PWM derating: each input word (signed temperature in 1/16 degree C and
// a requested 8-bit duty) yields one output word with the allowed duty and the
// thermal class (0 normal, 1 throttle, 2 critical). The block is a 7-stage
// pipeline: threshold compare, multiply, four divider stages of two quotient
// bits each, and the output register. It takes one word per cycle while the
// output is not stalled; a stalled output only holds back the stages behind
// it, so empty stages keep filling. The user must write the thresholds and
// duty floor through the configuration port only while no word is in flight;
// the block itself does not enforce this.
`include "thermal_pwm_derating_top_assert.svh"

module thermal_pwm_derating_top
	import tpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TEMP_W-1:0]     temperature,
	input  logic [DUTY_W-1:0]     requested_duty,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DUTY_W-1:0]     allowed_duty,
	output logic [CLS_W-1:0]      thermal_class
);

	localparam int NUM_STG  = DIV_STAGES + 3;
	localparam int STG_MUL  = 1;
	localparam int STG_DIV0 = 2;
	localparam int STG_LAST = NUM_STG - 1;

	cfg_t              cfg;
	prep_t             prep_q;
	work_t             mul_q;
	work_t             div_q [DIV_STAGES];
	work_t             div_last;
	logic [NUM_STG-1:0] valid_q;
	logic [NUM_STG-1:0] adv;
	logic [DUTY_W-1:0] duty_d;
	logic [DUTY_W-1:0] out_duty_q;
	logic [CLS_W-1:0]  out_cls_q;

	tpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage advance: a stage moves when empty or when the next one moves
	always_comb begin
		adv[STG_LAST] = !valid_q[STG_LAST] || !out_stall;
		for (int k = STG_LAST - 1; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	// valid bits travel with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	tpd_prep u_prep (
		.clk            (clk),
		.load           (adv[0]),
		.cfg            (cfg),
		.temperature    (temperature),
		.requested_duty (requested_duty),
		.q              (prep_q)
	);

	tpd_mul u_mul (
		.clk  (clk),
		.load (adv[STG_MUL]),
		.d    (prep_q),
		.q    (mul_q)
	);

	// divider chain
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		tpd_div_stage #(
			.QBIT_HI (QUOT_W - 1 - g * DIV_BITS_PER_STAGE)
		) u_div (
			.clk  (clk),
			.load (adv[STG_DIV0 + g]),
			.d    ((g == 0) ? mul_q : div_q[(g == 0) ? 0 : g - 1]),
			.q    (div_q[g])
		);
	end

	assign div_last = div_q[DIV_STAGES-1];

	// final duty selection
	always_comb begin
		case (div_last.mode)
			MODE_FLOOR: duty_d = div_last.floor_duty;
			MODE_REQ:   duty_d = div_last.req;
			MODE_RAMP:  duty_d = div_last.floor_duty + div_last.quot;
			default:    duty_d = div_last.req;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv[STG_LAST]) begin
			out_duty_q <= duty_d;
			out_cls_q  <= div_last.cls;
		end
	end

	assign out_valid     = valid_q[STG_LAST];
	assign allowed_duty  = out_duty_q;
	assign thermal_class = out_cls_q;

	// checks
	`TPD_ASSERT_NXT(a_accept_lands, in_valid && !in_stall, valid_q[0], "accepted word lost at stage 1")
	`TPD_ASSERT_NOW(a_stall_full, in_stall, valid_q[0] && valid_q[STG_LAST], "input stalled with room")
	`TPD_ASSERT_NOW(a_ramp_bound, valid_q[STG_LAST-1] && div_last.mode == MODE_RAMP, (div_last.quot <= div_last.req - div_last.floor_duty) && (div_last.rem < PROD_W'(div_last.den)), "ramp quotient out of range")
	`TPD_ASSERT_NOW(a_class_code, out_valid, thermal_class != CLS_UNUSED, "reserved thermal class")

endmodule
